// ===== sv/gss_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath interface types
// for the gauss-seidel solver; no dependencies

package gss_pkg;

  localparam int ROWS   = 64;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int MAT_AW = $clog2(ROWS * ROWS);
  localparam int ACC_W  = 48 + $clog2(ROWS) + 2;

  localparam logic [31:0] ONE_Q = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_WR_MAT = 2'd0,
    OP_WR_RHS = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SOLVE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CONV  = 2'd0,
    ST_ZDIAG = 2'd1,
    ST_LIMIT = 2'd2
  } status_t;

  localparam logic [1:0] CFG_TOL  = 2'd0;
  localparam logic [1:0] CFG_MAX  = 2'd1;
  localparam logic [1:0] CFG_ROWS = 2'd2;

  typedef struct packed {
    logic              clr_we;
    logic [MAT_AW-1:0] clr_addr;
    logic              ld_mat;
    logic              ld_rhs;
    logic              solve_init;
    logic              sweep_inc;
    logic              acc_clear;
    logic              issue;
    logic              issue_diag;
    logic              excl_diag;
    logic [ROW_W-1:0]  row_i;
    logic [ROW_W-1:0]  col_j;
    logic              div_start;
    logic              sol_we;
    logic              res_add;
    logic              sweep_end;
    logic              out_load;
    status_t           out_status;
    logic [ROW_W-1:0]  out_index;
    logic              out_zero;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic             pipe_busy;
    logic             div_busy;
    logic             diag_small;
    logic             keep_going;
    logic             limit_hit;
    logic [ROW_W-1:0] n_last;
  } stat_t;

endpackage

// ===== sv/gauss_seidel_solver_unit.sv =====
`timescale 1ns / 1ps
// Gauss-Seidel solver in signed Q16.16. Load requests (matrix entry, rhs entry)
// are accepted back to back while the unit is idle. After reset and after a
// clear request, a clearing pass over all ROWS*ROWS (4096) matrix addresses
// runs while input is stalled; config writes are still taken. A solve request
// runs sweeps over n active rows; each sweep has a check, the in-place update
// (one multiply-accumulate per column, a pipeline drain, a pivot test, a
// bit-serial divide and a write-back per row) and the residual pass. Results
// then leave one at a time, each held while out_stall is high: n solution
// values, or a single zero-diagonal report. Top level:
// gauss_seidel_solver_unit; uses gss_pkg, gss_ctrl, gss_dpath.

module gauss_seidel_solver_unit import gss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [5:0]         index,
  output logic signed [31:0] solution,
  output logic [15:0]        sweeps,
  output logic [31:0]        residual,
  output logic               last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  cmd_t  cmd;
  stat_t st;

  gss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  gss_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .row       (row),
    .col       (col),
    .value     (value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .index     (index),
    .solution  (solution),
    .sweeps    (sweeps),
    .residual  (residual),
    .last      (last)
  );

endmodule

// ===== sv/gss_dpath.sv =====
`timescale 1ns / 1ps
// datapath: config registers, matrix/rhs/solution memories, mac pipeline,
// restoring divider, residual accumulation and output registers; uses gss_pkg

module gss_dpath import gss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [5:0]         row,
  input  logic [5:0]         col,
  input  logic signed [31:0] value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output logic [1:0]         status,
  output logic [5:0]         index,
  output logic signed [31:0] solution,
  output logic [15:0]        sweeps,
  output logic [31:0]        residual,
  output logic               last
);

  localparam logic signed [ACC_W-1:0] NUM_LIM = ACC_W'((64'sd1 <<< 47) - 64'sd1);

  logic [30:0] tolerance;
  logic [15:0] max_sweeps;
  logic [6:0]  active_rows;

  logic signed [31:0] mat_mem [ROWS*ROWS];
  logic signed [31:0] rhs_mem [ROWS];
  logic signed [31:0] sol_mem [ROWS];

  logic              mat_we, rhs_we, sol_we;
  logic [MAT_AW-1:0] mat_wa, mat_ra;
  logic [ROW_W-1:0]  rhs_wa, sol_wa;
  logic signed [31:0] mat_wd, rhs_wd, sol_wd;
  logic signed [31:0] a_rd, b_rd, x_rd;

  logic v1, v2, d1, s1, s2;
  logic signed [63:0] prod;
  logic signed [31:0] aii;
  logic signed [ACC_W-1:0] acc;

  logic [61:0] tsq;
  logic [45:0] dlim;
  logic [32:0] amag;

  logic signed [ACC_W-1:0] num, numc;
  logic [47:0] mag;
  logic        num_neg;

  logic [63:0] dvd, quo;
  logic [33:0] rem, trial;
  logic [32:0] dmag;
  logic [6:0]  dcnt;
  logic        dbusy, qneg;
  logic signed [31:0] quot_sat;

  logic signed [ACC_W-1:0] dres, dabs;
  logic [31:0] tsat, err, err_new;
  logic [32:0] esum;

  logic [15:0] sweep_q;
  logic [31:0] residual_q;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance   <= 31'd65;
      max_sweeps  <= 16'd1000;
      active_rows <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOL:  tolerance   <= cfg_data;
        CFG_MAX:  max_sweeps  <= cfg_data[15:0];
        CFG_ROWS: active_rows <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (active_rows == 7'd0) begin
      st.n_last = '0;
    end else if (int'(active_rows) > ROWS) begin
      st.n_last = ROW_W'(ROWS - 1);
    end else begin
      st.n_last = ROW_W'(active_rows - 7'd1);
    end
  end

  // memory write muxes
  always_comb begin
    mat_we = 1'b0;
    mat_wa = cmd.clr_addr;
    mat_wd = '0;
    rhs_we = 1'b0;
    rhs_wa = cmd.clr_addr[ROW_W-1:0];
    rhs_wd = '0;
    sol_we = 1'b0;
    sol_wa = cmd.clr_addr[ROW_W-1:0];
    sol_wd = '0;
    if (cmd.clr_we) begin
      mat_we = 1'b1;
      rhs_we = 1'b1;
      sol_we = 1'b1;
    end else begin
      if (cmd.ld_mat && int'(row) < ROWS && int'(col) < ROWS) begin
        mat_we = 1'b1;
        mat_wa = MAT_AW'(int'(row) * ROWS + int'(col));
        mat_wd = value;
      end
      if (cmd.ld_rhs && int'(row) < ROWS) begin
        rhs_we = 1'b1;
        rhs_wa = ROW_W'(row);
        rhs_wd = value;
      end
      if (cmd.sol_we) begin
        sol_we = 1'b1;
        sol_wa = cmd.row_i;
        sol_wd = quot_sat;
      end
    end
  end

  assign mat_ra = MAT_AW'(int'(cmd.row_i) * ROWS + int'(cmd.col_j));

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_wa] <= mat_wd;
    end
    a_rd <= mat_mem[mat_ra];
  end

  always_ff @(posedge clk) begin
    if (rhs_we) begin
      rhs_mem[rhs_wa] <= rhs_wd;
    end
    b_rd <= rhs_mem[cmd.row_i];
  end

  always_ff @(posedge clk) begin
    if (sol_we) begin
      sol_mem[sol_wa] <= sol_wd;
    end
    x_rd <= sol_mem[cmd.col_j];
  end

  // mac pipeline: read, multiply, floor and accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
    d1   <= cmd.issue_diag;
    s1   <= cmd.issue_diag && cmd.excl_diag;
    s2   <= s1;
    prod <= a_rd * x_rd;
    if (v1 && d1) begin
      aii <= a_rd;
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (v2 && !s2) begin
      acc <= acc + ACC_W'(prod >>> 16);
    end
  end

  assign st.pipe_busy = v1 | v2;

  // zero-diagonal limit
  assign tsq  = 62'(tolerance) * 62'(tolerance);
  assign amag = aii[31] ? (33'd0 - {aii[31], aii}) : {1'b0, aii};
  assign st.diag_small = {13'd0, amag} <= dlim;

  // divider operand prep
  always_comb begin
    num  = ACC_W'(b_rd) - acc;
    numc = num;
    if (num > NUM_LIM) begin
      numc = NUM_LIM;
    end else if (num < -NUM_LIM) begin
      numc = -NUM_LIM;
    end
    num_neg = numc[ACC_W-1];
    mag     = num_neg ? 48'(-numc) : 48'(numc);
  end

  assign trial = {rem[32:0], dvd[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
    end else if (dbusy && dcnt == 7'd63) begin
      dbusy <= 1'b0;
    end
    if (cmd.div_start) begin
      dvd  <= {mag, 16'd0};
      rem  <= '0;
      quo  <= '0;
      dcnt <= '0;
      dmag <= amag;
      qneg <= num_neg ^ aii[31];
    end else if (dbusy) begin
      dvd  <= {dvd[62:0], 1'b0};
      dcnt <= dcnt + 7'd1;
      if (trial >= {1'b0, dmag}) begin
        rem <= trial - {1'b0, dmag};
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign st.div_busy = dbusy;

  always_comb begin
    if (qneg) begin
      quot_sat = (quo > 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - quo);
    end else begin
      quot_sat = (quo > 64'h7fff_ffff) ? 32'sh7fff_ffff : quo[31:0];
    end
  end

  // residual term and saturating sum
  always_comb begin
    dres    = acc - ACC_W'(b_rd);
    dabs    = dres[ACC_W-1] ? -dres : dres;
    tsat    = (|dabs[ACC_W-1:32]) ? 32'hffff_ffff : dabs[31:0];
    esum    = {1'b0, err} + {1'b0, tsat};
    err_new = esum[32] ? 32'hffff_ffff : esum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_q    <= '0;
      residual_q <= '0;
    end else begin
      if (cmd.solve_init) begin
        sweep_q    <= '0;
        residual_q <= ONE_Q;
        dlim       <= tsq[61:16];
      end
      if (cmd.sweep_inc) begin
        sweep_q <= sweep_q + 16'd1;
        err     <= '0;
      end
      if (cmd.res_add) begin
        err <= err_new;
      end
      if (cmd.sweep_end) begin
        residual_q <= err_new;
      end
    end
  end

  assign st.keep_going = (residual_q > {1'b0, tolerance}) && (sweep_q < max_sweeps);
  assign st.limit_hit  = sweep_q >= max_sweeps;

  // output registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status   <= cmd.out_status;
      index    <= 6'(cmd.out_index);
      solution <= cmd.out_zero ? 32'sd0 : x_rd;
      last     <= cmd.out_last;
    end
  end

  assign sweeps   = sweep_q;
  assign residual = residual_q;

endmodule

// ===== sv/gss_ctrl.sv =====
`timescale 1ns / 1ps
// controller: clearing pass, load decode, sweep/row/column sequencing and
// result delivery; uses gss_pkg

module gss_ctrl import gss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  output logic       out_valid,
  input  logic       out_stall,
  input  stat_t      st,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_ISSUE,
    S_DRAIN,
    S_TEST,
    S_DIV,
    S_WRITE,
    S_RISSUE,
    S_RDRAIN,
    S_RADD,
    S_OREAD,
    S_OLOAD,
    S_OWAIT
  } state_t;

  localparam logic [MAT_AW-1:0] CLR_LAST = MAT_AW'(ROWS * ROWS - 1);

  state_t            state;
  logic [MAT_AW-1:0] clr_cnt;
  logic [ROW_W-1:0]  ci, cj;
  logic              last_q;
  logic              accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    cmd.clr_addr   = clr_cnt;
    cmd.row_i      = ci;
    cmd.col_j      = cj;
    cmd.out_status = ST_CONV;
    cmd.out_index  = cj;
    cmd.ld_mat     = accept && op == OP_WR_MAT;
    cmd.ld_rhs     = accept && op == OP_WR_RHS;
    cmd.solve_init = accept && op == OP_SOLVE;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      S_CHECK: begin
        cmd.sweep_inc = st.keep_going;
        cmd.acc_clear = 1'b1;
      end
      S_ISSUE: begin
        cmd.issue      = 1'b1;
        cmd.issue_diag = (cj == ci);
        cmd.excl_diag  = 1'b1;
      end
      S_TEST: begin
        if (st.diag_small) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_ZDIAG;
          cmd.out_index  = ci;
          cmd.out_zero   = 1'b1;
          cmd.out_last   = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.sol_we    = 1'b1;
        cmd.acc_clear = 1'b1;
      end
      S_RISSUE: begin
        cmd.issue = 1'b1;
      end
      S_RADD: begin
        cmd.res_add   = 1'b1;
        cmd.acc_clear = 1'b1;
        cmd.sweep_end = (ci == st.n_last);
      end
      S_OLOAD: begin
        cmd.out_load   = 1'b1;
        cmd.out_status = st.limit_hit ? ST_LIMIT : ST_CONV;
        cmd.out_last   = (cj == st.n_last);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      ci        <= '0;
      cj        <= '0;
      out_valid <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && op == OP_CLEAR) begin
            clr_cnt <= '0;
            state   <= S_CLEAR;
          end else if (accept && op == OP_SOLVE) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          ci <= '0;
          cj <= '0;
          state <= st.keep_going ? S_ISSUE : S_OREAD;
        end
        S_ISSUE: begin
          if (cj == st.n_last) begin
            state <= S_DRAIN;
          end else begin
            cj <= cj + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!st.pipe_busy) begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (st.diag_small) begin
            out_valid <= 1'b1;
            last_q    <= 1'b1;
            state     <= S_OWAIT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!st.div_busy) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          cj <= '0;
          if (ci == st.n_last) begin
            ci    <= '0;
            state <= S_RISSUE;
          end else begin
            ci    <= ci + 1'b1;
            state <= S_ISSUE;
          end
        end
        S_RISSUE: begin
          if (cj == st.n_last) begin
            state <= S_RDRAIN;
          end else begin
            cj <= cj + 1'b1;
          end
        end
        S_RDRAIN: begin
          if (!st.pipe_busy) begin
            state <= S_RADD;
          end
        end
        S_RADD: begin
          cj <= '0;
          if (ci == st.n_last) begin
            state <= S_CHECK;
          end else begin
            ci    <= ci + 1'b1;
            state <= S_RISSUE;
          end
        end
        S_OREAD: begin
          state <= S_OLOAD;
        end
        S_OLOAD: begin
          out_valid <= 1'b1;
          last_q    <= (cj == st.n_last);
          state     <= S_OWAIT;
        end
        S_OWAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_q) begin
              state <= S_IDLE;
            end else begin
              cj    <= cj + 1'b1;
              state <= S_OREAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_solve_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_SOLVE) |=> in_stall)
    else $error("solve request did not block the input");

  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (!st.div_busy && !st.pipe_busy))
    else $error("divide started while busy");

  a_issue_no_div: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !st.div_busy)
    else $error("mac issue during divide");

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OWAIT)
    else $error("result valid outside delivery");
`endif

endmodule

// ===== tb/sv/gauss_seidel_solver_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for gauss_seidel_solver_unit: loads, clears and solves
// checked against a built-in fixed-point gauss-seidel predictor; uses gss_pkg

module gauss_seidel_solver_unit_tb;
  import gss_pkg::*;

  localparam int WATCH_LIMIT = 200000;

  typedef struct {
    op_t                op;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
  } req_t;

  typedef struct {
    status_t            status;
    logic [5:0]         index;
    logic signed [31:0] solution;
    logic [15:0]        sweeps;
    logic [31:0]        residual;
    logic               last;
  } sol_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [5:0] row = '0;
  logic [5:0] col = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic [5:0] index;
  logic signed [31:0] solution;
  logic [15:0] sweeps;
  logic [31:0] residual;
  logic last;
  logic cfg_we = 0;
  logic [1:0] cfg_index = CFG_TOL;
  logic [30:0] cfg_data = '0;

  gauss_seidel_solver_unit DUT (.*);

  always #1 clk = ~clk;

  // predictor state
  logic signed [31:0] mat_q [ROWS*ROWS];
  logic signed [31:0] rhs_q [ROWS];
  logic signed [31:0] x_q [ROWS];
  logic [30:0] tol_q = 31'd65;
  logic [15:0] max_sw_q = 16'd1000;
  logic [6:0]  rows_q = 7'd64;

  req_t pending_reqs[$];
  sol_t expected_sols[$];
  int n_sent = 0;
  int n_taken = 0;
  int n_errors = 0;
  int idle_cycles = 0;
  bit took = 0;

  function automatic longint prod_q(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] quot_q(longint num, logic signed [31:0] den);
    bit neg;
    longint unsigned mag, dmag, q;
    if (num > 64'sd140737488355327) num = 64'sd140737488355327;
    if (num < -64'sd140737488355327) num = -64'sd140737488355327;
    neg = num < 0;
    mag = neg ? -num : num;
    if (den < 0) begin
      neg = !neg;
      dmag = -longint'(den);
    end else begin
      dmag = longint'(den);
    end
    if (dmag == 0) return 0;
    q = (mag << 16) / dmag;
    if (neg) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      return 32'(-q);
    end
    if (q > 64'd2147483647) q = 64'd2147483647;
    return 32'(q);
  endfunction

  task automatic run_solve();
    int n, i, j;
    longint unsigned dlim, err, t;
    longint acc, d;
    int unsigned sw;
    logic [31:0] res;
    logic signed [31:0] aii;
    sol_t s;
    n = (rows_q < 1) ? 1 : (rows_q > ROWS) ? ROWS : rows_q;
    dlim = (longint'(tol_q) * longint'(tol_q)) >> 16;
    sw = 0;
    res = ONE_Q;
    while (res > tol_q && sw < max_sw_q) begin
      sw++;
      for (i = 0; i < n; i++) begin
        acc = 0;
        aii = mat_q[i*ROWS+i];
        for (j = 0; j < n; j++)
          if (j != i) acc += prod_q(mat_q[i*ROWS+j], x_q[j]);
        if ((aii < 0 ? -longint'(aii) : longint'(aii)) <= dlim) begin
          s = '{ST_ZDIAG, i[5:0], 32'sd0, sw[15:0], res, 1'b1};
          expected_sols.push_back(s);
          return;
        end
        x_q[i] = quot_q(longint'(rhs_q[i]) - acc, aii);
      end
      err = 0;
      for (i = 0; i < n; i++) begin
        acc = 0;
        for (j = 0; j < n; j++) acc += prod_q(mat_q[i*ROWS+j], x_q[j]);
        d = acc - longint'(rhs_q[i]);
        t = d < 0 ? -d : d;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        err += t;
        if (err > 64'hFFFF_FFFF) err = 64'hFFFF_FFFF;
      end
      res = err[31:0];
    end
    for (i = 0; i < n; i++) begin
      s = '{(sw >= max_sw_q) ? ST_LIMIT : ST_CONV, i[5:0], x_q[i], sw[15:0], res,
            i == n - 1};
      expected_sols.push_back(s);
    end
  endtask

  task automatic predict_request(req_t r);
    case (r.op)
      OP_WR_MAT: mat_q[r.row*ROWS+r.col] = r.value;
      OP_WR_RHS: rhs_q[r.row] = r.value;
      OP_CLEAR: begin
        foreach (mat_q[k]) mat_q[k] = 0;
        foreach (rhs_q[k]) begin
          rhs_q[k] = 0;
          x_q[k] = 0;
        end
      end
      default: run_solve();
    endcase
  endtask

  // input side: acceptance, prediction, watchdog
  always @(posedge clk) begin
    req_t r;
    took = in_valid && !in_stall && !rst;
    if (took) begin
      r = '{op_t'(op), row, col, value};
      predict_request(r);
      n_taken++;
    end
    if (rst || took || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("gauss_seidel_solver_unit_tb: errors");
      $finish;
    end
  end

  // request driver: bursts and gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk) begin
    req_t r;
    if (rst || (in_valid && !took)) begin
    end else if (gap_left > 0) begin
      in_valid <= 0;
      gap_left--;
    end else if (pending_reqs.size() > 0) begin
      r = pending_reqs.pop_front();
      in_valid <= 1;
      op <= r.op;
      row <= r.row;
      col <= r.col;
      value <= r.value;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 0;
    end
  end

  // result stall pattern
  int stall_mode = 0;
  int mode_left = 30;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(5, 60);
    end else mode_left--;
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    sol_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sols.size() == 0) begin
        $error("unexpected result index %0d", index);
        n_errors++;
      end else begin
        e = expected_sols.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); n_errors++;
        end
        if (index !== e.index) begin
          $error("index exp %0d got %0d", e.index, index); n_errors++;
        end
        if (solution !== e.solution) begin
          $error("solution exp %0d got %0d", e.solution, solution); n_errors++;
        end
        if (sweeps !== e.sweeps) begin
          $error("sweeps exp %0d got %0d", e.sweeps, sweeps); n_errors++;
        end
        if (residual !== e.residual) begin
          $error("residual exp %0d got %0d", e.residual, residual); n_errors++;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); n_errors++;
        end
      end
    end
  end

  task automatic send(op_t o, int r, int c, logic signed [31:0] v);
    req_t q;
    q = '{o, r[5:0], c[5:0], v};
    pending_reqs.push_back(q);
    n_sent++;
  endtask

  task automatic drain();
    while (n_taken < n_sent || expected_sols.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [30:0] data);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_TOL: tol_q = data;
      CFG_MAX: max_sw_q = data[15:0];
      default: rows_q = data[6:0];
    endcase
  endtask

  task automatic set_cfg(logic [30:0] tol, logic [15:0] mx, logic [6:0] n);
    write_cfg(CFG_TOL, tol);
    write_cfg(CFG_MAX, {15'd0, mx});
    write_cfg(CFG_ROWS, {24'd0, n});
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic signed [31:0] small_val(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // diagonally dominant system with random content
  task automatic load_system(int n);
    logic signed [31:0] dg;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (i == j) begin
          dg = (n + 1) * 65536 + $urandom_range(0, 65536);
          send(OP_WR_MAT, i, j, ($urandom_range(0, 1) != 0) ? -dg : dg);
        end else if ($urandom_range(0, 3) != 0) begin
          send(OP_WR_MAT, i, j, small_val(65536));
        end
      end
      send(OP_WR_RHS, i, 0, small_val(1 << 21));
    end
  endtask

  task automatic noise();
    op_t o;
    o = op_t'($urandom_range(0, 3));
    send(o, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
  endtask

  initial begin
    int rand_items, n, base;
    foreach (mat_q[k]) mat_q[k] = 0;
    foreach (rhs_q[k]) begin
      rhs_q[k] = 0;
      x_q[k] = 0;
    end
    repeat (6) @(negedge clk);
    rst <= 0;

    // defaults: zero diagonal on the second row, then on the first
    send(OP_WR_MAT, 0, 0, 32'sh7FFF_FFFF);
    send(OP_WR_MAT, 63, 63, 32'sh8000_0000);
    send(OP_WR_RHS, 63, 0, -32'sd1);
    send(OP_WR_RHS, 0, 0, 32'sh8000_0000);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_CLEAR, 0, 0, 0);
    send(OP_SOLVE, 0, 0, 0);
    drain();

    // maximum tolerance, all rows: no sweep at all
    set_cfg(31'h7FFF_FFFF, 16'hFFFF, 7'd127);
    send(OP_WR_RHS, 5, 0, 32'sh0001_0000);
    send(OP_SOLVE, 0, 0, 0);
    drain();

    // sweep limit of zero, active rows zero
    set_cfg(31'd0, 16'd0, 7'd0);
    send(OP_SOLVE, 0, 0, 0);
    drain();

    // single unknown: converges, then a tiny pivot
    set_cfg(31'd1000, 16'hFFFF, 7'd1);
    send(OP_CLEAR, 0, 0, 0);
    send(OP_WR_MAT, 0, 0, 32'sh0002_0000);
    send(OP_WR_RHS, 0, 0, 32'sh0003_0000);
    send(OP_SOLVE, 0, 0, 0);
    send(OP_WR_MAT, 0, 0, 32'sd1);
    send(OP_SOLVE, 0, 0, 0);
    drain();

    rand_items = 0;
    while (rand_items < 250) begin
      n = $urandom_range(2, 6);
      case ($urandom_range(0, 2))
        0: set_cfg(31'd0, 16'($urandom_range(1, 20)), 7'(n));
        1: set_cfg(31'($urandom_range(0, 5000)), 16'($urandom_range(1, 20)), 7'(n));
        default: set_cfg(31'd65536, 16'($urandom_range(1, 20)), 7'(n));
      endcase
      repeat ($urandom_range(1, 3)) begin
        base = n_sent;
        send(OP_CLEAR, 0, 0, 0);
        load_system(n);
        repeat ($urandom_range(0, 3)) noise();
        send(OP_SOLVE, 0, 0, 0);
        if ($urandom_range(0, 2) == 0) begin
          send(OP_WR_RHS, $urandom_range(0, n - 1), 0, small_val(1 << 20));
          send(OP_SOLVE, 0, 0, 0);
        end
        rand_items += n_sent - base;
      end
      drain();
    end

    if (n_errors == 0) $display("gauss_seidel_solver_unit_tb: clean");
    else $display("gauss_seidel_solver_unit_tb: errors");
    $finish;
  end

endmodule
